FILE: hdl/clpm_pkg.sv
`default_nettype none
package clpm_pkg;

    localparam int unsigned DIST_W    = 18;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned CELL_W    = 6;
    localparam int unsigned MAX_RES   = 32;

    typedef enum logic [1:0] {
        FUNC_LOAD_A = 2'd0,
        FUNC_LOAD_B = 2'd1,
        FUNC_RUN    = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [DIST_W-1:0] point_distance;
    } in_item_t;

    typedef struct packed {
        logic             pair_valid;
        logic [IDX_W-1:0] index_a;
        logic [IDX_W-1:0] index_b;
        logic             last;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic fill_start;
        logic fill_step;
        logic trace_start;
        logic trace_rd;
        logic trace_step;
        logic clear_lists;
    } dp_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic fill_done;
        logic trace_done;
        logic take;
    } dp_sts_t;

endpackage
`default_nettype wire

FILE: hdl/clpm_datapath.sv
`default_nettype none
module clpm_datapath
    import clpm_pkg::*;
#(
    parameter int unsigned MAX_POINTS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_cmd_t           cmd,
    input  wire logic [DIST_W-1:0] load_dist,
    input  wire logic [DIST_W-1:0] window,
    output dp_sts_t                sts,
    output logic [IDX_W-1:0]       pair_a,
    output logic [IDX_W-1:0]       pair_b
);

    localparam int unsigned EXT  = 2 * MAX_POINTS;
    localparam int unsigned CW   = $clog2(MAX_POINTS + 1);
    localparam int unsigned LW   = $clog2(MAX_POINTS);
    localparam int unsigned XW   = $clog2(EXT + 1);
    localparam int unsigned UW   = $clog2(EXT);
    localparam int unsigned GDIM = EXT + 1;
    localparam int unsigned GW   = $clog2(GDIM * GDIM);

    logic [DIST_W-1:0] list_a [MAX_POINTS];
    logic [DIST_W-1:0] list_b [MAX_POINTS];
    logic [CW-1:0] cnt_a_reg, cnt_b_reg;
    logic [XW-1:0] row_reg, col_reg;
    logic [CELL_W-1:0] grid [GDIM * GDIM];
    logic [CELL_W-1:0] left_reg;
    logic [CELL_W-1:0] up   [EXT];
    logic [CELL_W-1:0] diag_reg;
    logic [CELL_W-1:0] t_here_reg, t_diag_reg, t_left_reg, t_up_reg;

    logic [XW-1:0] n1, n2;
    assign n1 = XW'({cnt_a_reg, 1'b0});
    assign n2 = XW'({cnt_b_reg, 1'b0});

    function automatic logic [XW-1:0] wrap(input logic [XW-1:0] e, input logic [CW-1:0] n);
        return (e >= XW'(n)) ? e - XW'(n) : e;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.load_a && (cnt_a_reg < CW'(MAX_POINTS)))
            list_a[cnt_a_reg[LW-1:0]] <= load_dist;
        if (cmd.load_b && (cnt_b_reg < CW'(MAX_POINTS)))
            list_b[cnt_b_reg[LW-1:0]] <= load_dist;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
        end
        else if (cmd.clear_lists)
        begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
        end
        else
        begin
            if (cmd.load_a && (cnt_a_reg < CW'(MAX_POINTS)))
                cnt_a_reg <= cnt_a_reg + 1'b1;
            if (cmd.load_b && (cnt_b_reg < CW'(MAX_POINTS)))
                cnt_b_reg <= cnt_b_reg + 1'b1;
        end
    end

    // Fill: one cell per cycle in row order; the previous row lives in up[],
    // which reads as zero while the first row is filled.
    logic [DIST_W-1:0] da, db, diff;
    logic [CELL_W-1:0] best, cand, up_val;
    logic [XW-1:0]     ea, eb, col_m1;
    assign ea     = wrap(row_reg - 1'b1, cnt_a_reg);
    assign eb     = wrap(col_reg - 1'b1, cnt_b_reg);
    assign da     = list_a[ea[LW-1:0]];
    assign db     = list_b[eb[LW-1:0]];
    assign diff   = (da > db) ? da - db : db - da;
    assign col_m1 = col_reg - 1'b1;
    assign up_val = (row_reg == XW'(1)) ? '0 : up[col_m1[UW-1:0]];

    always_comb
    begin
        cand = diag_reg + CELL_W'(diff < window);
        best = cand;
        if (left_reg > best)
            best = left_reg;
        if (up_val > best)
            best = up_val;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_step)
            up[col_m1[UW-1:0]] <= best;
    end

    logic [GW-1:0] waddr, raddr;
    logic [XW-1:0] rr, rc;
    assign waddr = GW'(row_reg * GDIM + col_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.fill_step && row_reg != '0 && col_reg != '0)
            grid[waddr] <= best;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            left_reg <= '0;
            diag_reg <= '0;
        end
        else if (cmd.fill_start)
        begin
            row_reg  <= XW'(1);
            col_reg  <= XW'(1);
            left_reg <= '0;
            diag_reg <= '0;
        end
        else if (cmd.fill_step)
        begin
            if (col_reg == n2)
            begin
                row_reg  <= row_reg + 1'b1;
                col_reg  <= XW'(1);
                left_reg <= '0;
                diag_reg <= '0;
            end
            else
            begin
                col_reg  <= col_reg + 1'b1;
                left_reg <= best;
                diag_reg <= up_val;
            end
        end
        else if (cmd.trace_start)
        begin
            row_reg <= n1;
            col_reg <= n2;
        end
        else if (cmd.trace_step)
        begin
            if (t_here_reg == t_diag_reg || sts.take)
            begin
                row_reg <= row_reg - 1'b1;
                col_reg <= col_reg - 1'b1;
            end
            else if (t_here_reg == t_left_reg)
                col_reg <= col_reg - 1'b1;
            else
                row_reg <= row_reg - 1'b1;
        end
    end

    // Traceback reads the cell and its three neighbors in turn through one port.
    logic [1:0] rd_sel_reg;
    logic [CELL_W-1:0] rdata_reg;
    logic              zero_reg;
    always_comb
    begin
        rr = row_reg;
        rc = col_reg;
        case (rd_sel_reg)
            2'd1: begin rr = row_reg - 1'b1; rc = col_reg - 1'b1; end
            2'd2: rc = col_reg - 1'b1;
            2'd3: rr = row_reg - 1'b1;
            default: ;
        endcase
        raddr = GW'(rr * GDIM + rc);
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= grid[raddr];
        zero_reg  <= (rr == '0) || (rc == '0);
    end

    logic [2:0] phase_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_sel_reg <= '0;
            phase_reg  <= '0;
        end
        else if (cmd.trace_rd)
        begin
            rd_sel_reg <= rd_sel_reg + 1'b1;
            phase_reg  <= (phase_reg == 3'd4) ? 3'd0 : phase_reg + 1'b1;
        end
        else
        begin
            rd_sel_reg <= '0;
            phase_reg  <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.trace_rd && phase_reg != 3'd0)
        begin
            case (phase_reg)
                3'd1: t_here_reg <= zero_reg ? '0 : rdata_reg;
                3'd2: t_diag_reg <= zero_reg ? '0 : rdata_reg;
                3'd3: t_left_reg <= zero_reg ? '0 : rdata_reg;
                default: t_up_reg <= zero_reg ? '0 : rdata_reg;
            endcase
        end
    end

    logic [XW-1:0] ia, ib;
    assign ia = wrap(row_reg - 1'b1, cnt_a_reg);
    assign ib = wrap(col_reg - 1'b1, cnt_b_reg);
    assign pair_a = ia[IDX_W-1:0];
    assign pair_b = ib[IDX_W-1:0];

    assign sts.fill_done  = (row_reg > n1) || (n2 == '0);
    assign sts.trace_done = (row_reg == '0) || (col_reg == '0);
    assign sts.take       = (t_here_reg != t_diag_reg) && (t_here_reg != t_left_reg)
                          && (t_here_reg != t_up_reg);

endmodule
`default_nettype wire

FILE: hdl/clpm_ctrl.sv
`default_nettype none
module clpm_ctrl
    import clpm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output dp_cmd_t        cmd,
    input  wire dp_sts_t   sts,
    input  wire logic [IDX_W-1:0] pair_a,
    input  wire logic [IDX_W-1:0] pair_b,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    typedef enum logic [2:0] {
        S_IDLE, S_FILL, S_TSTART, S_READ, S_DECIDE, S_EMIT, S_FLUSH
    } state_t;

    state_t            state_reg;
    logic [2:0]        rd_cnt_reg;
    logic [5:0]        emitted_reg;
    out_item_t         hold_reg;
    logic              hold_vld_reg;
    out_item_t         out_reg;
    logic              out_vld_reg;

    logic in_fire, out_free, keep_pair, out_load;
    assign in_ready = (state_reg == S_IDLE) && !out_vld_reg && !hold_vld_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_vld_reg || out_ready;
    assign out_valid = out_vld_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        cmd = '0;
        cmd.load_a = in_fire && (in_item.func == FUNC_LOAD_A);
        cmd.load_b = in_fire && (in_item.func == FUNC_LOAD_B);
        cmd.fill_start = in_fire && (in_item.func == FUNC_RUN);
        cmd.fill_step = (state_reg == S_FILL) && !sts.fill_done;
        cmd.trace_start = (state_reg == S_FILL) && sts.fill_done;
        cmd.trace_rd = (state_reg == S_READ);
        cmd.trace_step = (state_reg == S_DECIDE) && (!sts.take || out_free);
        cmd.clear_lists = (state_reg == S_FLUSH) && out_free;
    end

    // The output register is loaded when a take pushes out the held pair or
    // when the run ends.
    assign keep_pair = cmd.trace_step && sts.take && (emitted_reg < 6'(MAX_RES));
    assign out_load  = (keep_pair && hold_vld_reg) || cmd.clear_lists;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rd_cnt_reg   <= '0;
            emitted_reg  <= '0;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            hold_reg     <= '0;
            out_reg      <= '0;
        end
        else
        begin
            if (out_load)
                out_vld_reg <= 1'b1;
            else if (out_vld_reg && out_ready)
                out_vld_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (cmd.fill_start)
                    begin
                        state_reg   <= S_FILL;
                        emitted_reg <= '0;
                    end
                S_FILL:
                    if (sts.fill_done)
                        state_reg <= S_TSTART;
                S_TSTART:
                    if (sts.trace_done)
                        state_reg <= S_FLUSH;
                    else
                    begin
                        state_reg  <= S_READ;
                        rd_cnt_reg <= '0;
                    end
                S_READ:
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    if (rd_cnt_reg == 3'd4)
                        state_reg <= S_DECIDE;
                end
                S_DECIDE:
                    if (cmd.trace_step)
                    begin
                        // A take pushes the held pair out and keeps the new one,
                        // so the final pair can still get its last flag.
                        if (keep_pair)
                        begin
                            if (hold_vld_reg)
                                out_reg <= hold_reg;
                            hold_reg     <= '{pair_valid: 1'b1, index_a: pair_a,
                                              index_b: pair_b, last: 1'b0};
                            hold_vld_reg <= 1'b1;
                            emitted_reg  <= emitted_reg + 1'b1;
                        end
                        state_reg <= S_TSTART;
                    end
                S_FLUSH:
                    if (out_free)
                    begin
                        out_reg.pair_valid <= hold_vld_reg;
                        out_reg.index_a    <= hold_vld_reg ? hold_reg.index_a : '0;
                        out_reg.index_b    <= hold_vld_reg ? hold_reg.index_b : '0;
                        out_reg.last       <= 1'b1;
                        hold_vld_reg       <= 1'b0;
                        state_reg          <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hdl/circular_lcs_point_matcher.sv
// Circular LCS point matcher.
// Channels: in (valid/ready) carries one item of func and point_distance;
// out (valid/ready) carries matched index pairs; cfg (valid/ready) writes
// match_window, which is always ready and must only change while idle.
// A load item (func 0 or 1) produces no result.
// A run item (func 2) fills the doubled grid one cell per cycle, then traces
// back from the far corner, each step bounded by the single-port grid memory.
// Each matched pair is sent in traceback order; the final item has last set,
// and a run without matches sends one item with pair_valid clear.
// Input ready drops for the whole run; both lists are empty afterwards.
// When the receiver stalls, the traceback pauses at the next match, so no
// item is lost. Reset clears the counts and control state and restores
// match_window to 320; list and grid contents are left as they are.
`default_nettype none
module circular_lcs_point_matcher
    import clpm_pkg::*;
#(
    parameter int unsigned MAX_POINTS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_item_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [DIST_W-1:0] cfg_data
);

    logic [DIST_W-1:0] window_reg;
    dp_cmd_t cmd;
    dp_sts_t sts;
    logic [IDX_W-1:0] pair_a, pair_b;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= DIST_W'(320);
        else if (cfg_valid)
            window_reg <= cfg_data;
    end

    clpm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_item(in_data), .cmd(cmd), .sts(sts), .pair_a(pair_a), .pair_b(pair_b),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_data)
    );

    clpm_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .load_dist(in_data.point_distance),
        .window(window_reg), .sts(sts), .pair_a(pair_a), .pair_b(pair_b)
    );

endmodule
`default_nettype wire

FILE: hdl/clpm_checker.sv
`default_nettype none
module clpm_checker
    import clpm_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_nomatch_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.pair_valid |-> out_data.last)
        else $error("empty result without last");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while a result waits");

    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.pair_valid |-> out_data.index_a == '0
            && out_data.index_b == '0)
        else $error("empty result carries indexes");

endmodule

bind circular_lcs_point_matcher clpm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none
module tb_top;
    import clpm_pkg::*;

    // The grid of the doubled lists can hold up to 2 * 16 matches, so up to
    // 32 pairs may come out of one run.
    localparam int unsigned NPTS       = 16;
    localparam int unsigned PAIR_CAP   = 32;
    localparam int unsigned WIN_RESET  = 320;
    localparam int unsigned DIST_MAX   = 262143;
    localparam int unsigned SETTLE     = 64;
    localparam int unsigned LONG_HOLD  = 600;
    localparam int unsigned CYCLE_CAP  = 600000;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_ready;
    out_item_t        out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [DIST_W-1:0] cfg_data;

    circular_lcs_point_matcher u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Predictor state: the two lists, their fill counts and the window.
    logic [DIST_W-1:0] dists_a [NPTS];
    logic [DIST_W-1:0] dists_b [NPTS];
    int unsigned       fill_a;
    int unsigned       fill_b;
    logic [DIST_W-1:0] window_now;

    // Pairs that the block still owes us, oldest first.
    out_item_t pending_pairs[$];

    int unsigned error_count;
    int unsigned items_sent;
    int unsigned runs_sent;
    int unsigned pairs_seen;
    int unsigned empty_runs_seen;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned hold_left;
    logic        hold_request;

    // Clock with a period of 8 time units.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a stuck handshake must not hang the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("%0t: timeout with %0d pairs still pending", $time,
                     pending_pairs.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Fill the LCS grid of the doubled lists and trace it back, queueing the
    // pairs that the block should send. Both lists are emptied afterwards.
    function automatic void predict_match_run();
        int unsigned grid [0:2*NPTS][0:2*NPTS];
        int unsigned rows;
        int unsigned cols;
        int unsigned r;
        int unsigned c;
        int unsigned ka;
        int unsigned kb;
        int unsigned diff;
        int unsigned best;
        int unsigned here;
        int unsigned taken;
        out_item_t   pair;

        rows  = 2 * fill_a;
        cols  = 2 * fill_b;
        taken = 0;
        for (r = 0; r <= 2 * NPTS; r++)
            for (c = 0; c <= 2 * NPTS; c++)
                grid[r][c] = 0;

        for (r = 1; r <= rows; r++)
        begin
            for (c = 1; c <= cols; c++)
            begin
                ka   = (r - 1 >= fill_a) ? r - 1 - fill_a : r - 1;
                kb   = (c - 1 >= fill_b) ? c - 1 - fill_b : c - 1;
                diff = (dists_a[ka] > dists_b[kb]) ? dists_a[ka] - dists_b[kb]
                                                   : dists_b[kb] - dists_a[ka];
                best = grid[r-1][c-1] + ((diff < window_now) ? 1 : 0);
                if (grid[r][c-1] > best) best = grid[r][c-1];
                if (grid[r-1][c] > best) best = grid[r-1][c];
                grid[r][c] = best & 6'h3f;
            end
        end

        // Traceback: a skip, a step in B or a step in A wins over a take.
        r = rows;
        c = cols;
        while (r > 0 && c > 0)
        begin
            here = grid[r][c];
            if (here == grid[r-1][c-1])
            begin
                r--;
                c--;
            end
            else if (here == grid[r][c-1])
                c--;
            else if (here == grid[r-1][c])
                r--;
            else
            begin
                if (taken < PAIR_CAP)
                begin
                    pair.pair_valid = 1'b1;
                    pair.index_a    = IDX_W'((r - 1 >= fill_a) ? r - 1 - fill_a : r - 1);
                    pair.index_b    = IDX_W'((c - 1 >= fill_b) ? c - 1 - fill_b : c - 1);
                    pair.last       = 1'b0;
                    pending_pairs   = {pending_pairs, pair};
                    taken++;
                end
                r--;
                c--;
            end
        end

        if (taken == 0)
        begin
            pair = '0;
            pair.last = 1'b1;
            pending_pairs = {pending_pairs, pair};
        end
        else
            pending_pairs[pending_pairs.size()-1].last = 1'b1;

        fill_a = 0;
        fill_b = 0;
    endfunction

    // Update the predictor for one accepted item.
    function automatic void predict_item(in_item_t item);
        case (func_t'(item.func))
            FUNC_LOAD_A:
                if (fill_a < NPTS)
                begin
                    dists_a[fill_a] = item.point_distance;
                    fill_a++;
                end
            FUNC_LOAD_B:
                if (fill_b < NPTS)
                begin
                    dists_b[fill_b] = item.point_distance;
                    fill_b++;
                end
            FUNC_RUN:
                predict_match_run();
            default:
                ;
        endcase
    endfunction

    // Offer one item and hold it until the block takes it. The sender works
    // in bursts; between most bursts valid drops for a random pause.
    // Valid is left high after acceptance so back-to-back items never see a
    // low and a high assigned in the same step.
    task automatic send_item(input func_t f, input logic [DIST_W-1:0] distance_value);
        in_item_t item;
        logic     taken;

        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
        burst_left--;

        item.func           = f;
        item.point_distance = distance_value;
        in_valid <= 1'b1;
        in_data  <= item;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end while (!taken);

        predict_item(item);
        items_sent++;
        if (f == FUNC_RUN) runs_sent++;
    endtask

    // Drop valid at the edge that took the last item and wait until every
    // owed pair has arrived, then give the block time to settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        wait (pending_pairs.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write match_window. Only called while the block is idle.
    task automatic write_window(input logic [DIST_W-1:0] value);
        logic taken;

        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end while (!taken);
        cfg_valid  <= 1'b0;
        window_now  = value;
    endtask

    // Receiver: random stalls that switch between stall-free stretches and
    // choppy ones, plus a long hold-off when a test asks for it.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_request)
        begin
            hold_request <= 1'b0;
            hold_left    <= LONG_HOLD;
            out_ready    <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (cycle_count[9])
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    // Checker. Signals are stable at the falling edge, and an item seen with
    // valid and ready high there is the one the next rising edge accepts.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pairs.size() == 0)
            begin
                $display("%0t: unexpected item, actual %p", $time, out_data);
                error_count++;
            end
            else
            begin
                if (out_data.pair_valid !== pending_pairs[0].pair_valid)
                begin
                    $display("%0t: pair_valid expected %0d actual %0d", $time,
                             pending_pairs[0].pair_valid, out_data.pair_valid);
                    error_count++;
                end
                if (out_data.index_a !== pending_pairs[0].index_a)
                begin
                    $display("%0t: index_a expected %0d actual %0d", $time,
                             pending_pairs[0].index_a, out_data.index_a);
                    error_count++;
                end
                if (out_data.index_b !== pending_pairs[0].index_b)
                begin
                    $display("%0t: index_b expected %0d actual %0d", $time,
                             pending_pairs[0].index_b, out_data.index_b);
                    error_count++;
                end
                if (out_data.last !== pending_pairs[0].last)
                begin
                    $display("%0t: last expected %0d actual %0d", $time,
                             pending_pairs[0].last, out_data.last);
                    error_count++;
                end
                if (pending_pairs[0].pair_valid)
                    pairs_seen++;
                else
                    empty_runs_seen++;
                void'(pending_pairs.pop_front());
            end
        end
    end

    // Extreme distances, two exact matches and one far pair, at the reset
    // window. Both ends of the distance range appear in both lists.
    task automatic test_extremes();
        send_item(FUNC_LOAD_A, '0);
        send_item(FUNC_LOAD_A, DIST_MAX);
        send_item(FUNC_LOAD_A, 18'h15555);
        send_item(FUNC_LOAD_B, DIST_MAX);
        send_item(FUNC_LOAD_B, '0);
        send_item(FUNC_LOAD_B, 18'h2aaaa);
        send_item(FUNC_RUN, '0);
    endtask

    // A run on empty lists, and a run with only list A loaded, each give
    // the single item without a pair.
    task automatic test_empty_lists();
        send_item(FUNC_RUN, 18'h3ffff);
        send_item(FUNC_LOAD_A, 18'd100);
        send_item(FUNC_RUN, '0);
    endtask

    // The unused selector must be ignored entirely.
    task automatic test_unused_func();
        send_item(FUNC_NONE, 18'd500);
        send_item(FUNC_LOAD_A, 18'd500);
        send_item(FUNC_NONE, 18'd500);
        send_item(FUNC_LOAD_B, 18'd510);
        send_item(FUNC_RUN, '0);
    endtask

    // Appends past a full list are dropped; one list overfills, the other
    // fills exactly, so the run covers the largest grid.
    task automatic test_full_lists();
        int unsigned k;

        for (k = 0; k < NPTS + 2; k++)
            send_item(FUNC_LOAD_A, 18'd1000 + 18'(k * 40));
        for (k = 0; k < NPTS; k++)
            send_item(FUNC_LOAD_B, 18'd1000 + 18'(k * 40) + 18'($urandom_range(0, 30)));
        send_item(FUNC_RUN, '0);
    endtask

    // Window at both extremes: zero never matches and the maximum matches
    // almost everything.
    task automatic test_window_extremes();
        int unsigned k;

        write_window('0);
        send_item(FUNC_LOAD_A, 18'd7);
        send_item(FUNC_LOAD_B, 18'd7);
        send_item(FUNC_RUN, '0);
        write_window(18'(DIST_MAX));
        for (k = 0; k < 5; k++)
            send_item(FUNC_LOAD_A, 18'($urandom_range(0, DIST_MAX)));
        for (k = 0; k < 6; k++)
            send_item(FUNC_LOAD_B, 18'($urandom_range(0, DIST_MAX)));
        send_item(FUNC_RUN, '0);
        write_window(18'd1);
    endtask

    // One load sequence with random content: lists mostly small, distances
    // clustered round a base so that matches are common. Now and then an
    // unused selector is mixed in, or a list is left empty.
    task automatic send_random_run(input int unsigned spread);
        int unsigned na;
        int unsigned nb;
        int unsigned k;
        int unsigned base;

        na   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 6);
        nb   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 6);
        base = $urandom_range(0, DIST_MAX - spread);
        for (k = 0; k < na + nb; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_item(FUNC_NONE, 18'($urandom_range(0, DIST_MAX)));
            if ($urandom_range(0, 19) == 0)
                send_item(k < na ? FUNC_LOAD_A : FUNC_LOAD_B,
                          18'($urandom_range(0, DIST_MAX)));
            else
                send_item(k < na ? FUNC_LOAD_A : FUNC_LOAD_B,
                          18'(base + $urandom_range(0, spread)));
        end
        send_item(FUNC_RUN, 18'($urandom_range(0, DIST_MAX)));
    endtask

    // Random sequences under several window settings.
    task automatic test_random_runs();
        int unsigned start;

        start = items_sent;
        while (items_sent - start < 40)
        begin
            if ($urandom_range(0, 4) == 0)
                write_window(18'($urandom_range(1, 4000)));
            send_random_run($urandom_range(200, 3000));
        end
    endtask

    // Hold the receiver off for a long stretch while two runs are offered:
    // the first run stalls on its output, so the second one stalls on input.
    task automatic test_output_stall();
        wait_idle();
        hold_request = 1'b1;
        write_window(18'(WIN_RESET));
        send_random_run(600);
        send_random_run(600);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        out_ready    = 1'b0;
        hold_request = 1'b0;
        hold_left    = 0;
        cycle_count  = 0;
        error_count  = 0;
        items_sent   = 0;
        runs_sent    = 0;
        pairs_seen   = 0;
        empty_runs_seen = 0;
        burst_left   = 0;
        fill_a       = 0;
        fill_b       = 0;
        window_now   = WIN_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_empty_lists();
        test_unused_func();
        test_full_lists();
        test_window_extremes();
        test_random_runs();
        test_output_stall();
        write_window(18'(WIN_RESET));

        wait_idle();
        repeat (200) @(posedge clk);

        $display("Sent %0d items in %0d match runs; checked %0d pairs and %0d empty runs.",
                 items_sent, runs_sent, pairs_seen, empty_runs_seen);
        $display("Windows from zero to full scale, full lists and a long output stall.");
        if (error_count == 0 && pending_pairs.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
hdl/clpm_pkg.sv
hdl/clpm_datapath.sv
hdl/clpm_ctrl.sv
hdl/circular_lcs_point_matcher.sv
hdl/clpm_checker.sv
sim/tb_top.sv
